[rtl/pfa_pkg.sv]
// Shared types and constants of the paged frame allocator.
package pfa_pkg;

	// Request kinds carried in tuser.
	typedef enum logic [1:0] {
		FN_CREATE    = 2'd0,
		FN_TRANSLATE = 2'd1,
		FN_RESIZE    = 2'd2,
		FN_RELEASE   = 2'd3
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_OUT_OF_MEM  = 2'd1,
		ST_UNKNOWN     = 2'd2,
		ST_BAD_PAGE    = 2'd3
	} status_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_PAGE_SIZE  = 2'd0;
	localparam logic [1:0] REG_MEM_SIZE   = 2'd1;
	localparam logic [1:0] REG_FRAME_CNT  = 2'd2;

	// Field widths.
	localparam int PSW = 13;   // page size
	localparam int MSW = 21;   // byte sizes
	localparam int FCW = 8;    // frame count register
	localparam int PGW = 7;    // page index field
	localparam int FRW = 7;    // frame result field
	localparam int QW  = 22;   // rounded-up numerator and page quotient
	localparam int DCW = 5;    // divider step counter

	// Register reset values.
	localparam logic [PSW-1:0] PAGE_SIZE_RST = 13'd32;
	localparam logic [MSW-1:0] MEM_SIZE_RST  = 21'd4096;
	localparam logic [FCW-1:0] FRAME_CNT_RST = 8'd128;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;          // latch the request and look up its slot
		logic    create_apply;  // register the pid if needed
		logic    res_set;       // set result with res_code, frame zero
		status_t res_code;
		logic    div_start;     // start the page count division
		logic    keep_quot;     // shrink target is the new page count
		logic    keep_zero;     // shrink target is zero (release)
		logic    shr_read;      // drop one page and read its frame
		logic    free_step;     // give back the frame just read
		logic    slot_clear;    // free the slot
		logic    grow_init;     // start the free frame scan
		logic    grow_step;     // one frame of the scan
		logic    xl_read;       // read the page table for a translate
		logic    xl_result;     // result ok with the frame read
		logic    out_load;      // move the result to the output register
		logic    rc_init;       // start the free frame recount
		logic    rc_step;       // one frame of the recount
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		func_t func;
		logic  found;
		logic  page_ok;
		logic  div_done;
		logic  same;
		logic  shrink;
		logic  grow_fail;
		logic  more_free;
		logic  grow_more;
		logic  rc_more;
	} sts_t;

endpackage

[rtl/pfa_div.sv]
// Restoring divider that computes the page count one quotient bit per cycle.
module pfa_div
	import pfa_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [QW-1:0]  num,
	input  logic [PSW-1:0] den,
	output logic           done,
	output logic [QW-1:0]  quot
);

	logic [PSW-1:0] den_q;
	logic [PSW-1:0] rem_q;
	logic [QW-1:0]  quo_q;
	logic [DCW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [PSW:0]   trial;
	logic           fits;

	// Shift in the next numerator bit and try the subtraction.
	assign trial = {rem_q, quo_q[QW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCW'(QW - 1);
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
			end else if (busy_q) begin
				rem_q <= fits ? PSW'(trial - {1'b0, den_q}) : trial[PSW-1:0];
				quo_q <= {quo_q[QW-2:0], fits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

[rtl/pfa_dp.sv]
// Datapath: slot table, frame bitmap, free count, page table memory and result.
module pfa_dp
	import pfa_pkg::*;
#(
	parameter int FRAMES        = 128,
	parameter int PROCESS_SLOTS = 16,
	parameter int MAX_PAGES     = 128
)(
	input  logic           clk,
	input  logic           arst_n,
	input  cmd_t           cmd,
	output sts_t           sts,
	input  func_t          in_func,
	input  logic [7:0]     in_pid,
	input  logic [PGW-1:0] in_page,
	input  logic [MSW-1:0] in_size,
	input  logic [PSW-1:0] page_size,
	input  logic [MSW-1:0] mem_size,
	input  logic [FCW-1:0] frame_count,
	output status_t        out_status,
	output logic [FRW-1:0] out_frame
);

	localparam int SW    = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
	localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int FW    = $clog2(FRAMES);
	localparam int NW    = $clog2(FRAMES + 1);
	localparam int CW    = $clog2(MAX_PAGES + 1);
	localparam int LW    = (NW > FCW) ? NW : FCW;
	localparam int XW    = (CW > PGW) ? CW : PGW;
	localparam int DEPTH = PROCESS_SLOTS << PW;
	localparam logic [NW-1:0] FREE_RST =
		(FRAMES < 128) ? NW'(FRAMES) : NW'(FRAME_CNT_RST);

	// Latched request.
	func_t          func_q;
	logic [7:0]     pid_q;
	logic [PGW-1:0] page_q;
	logic [MSW-1:0] size_q;
	logic [SW-1:0]  slot_q;
	logic           found_q;

	// Slot table, bitmap and counters.
	logic [PROCESS_SLOTS-1:0] slot_valid_q;
	logic [7:0]               slot_pid_q   [PROCESS_SLOTS];
	logic [CW-1:0]            slot_pages_q [PROCESS_SLOTS];
	logic [FRAMES-1:0]        used_q;
	logic [NW-1:0]            free_q;
	logic [NW-1:0]            f_q;
	logic [CW-1:0]            keep_q;
	logic [CW-1:0]            target_q;

	// Result and output registers.
	status_t        res_status_q;
	logic [FRW-1:0] res_frame_q;
	status_t        out_status_q;
	logic [FRW-1:0] out_frame_q;

	// Page table memory.
	logic [FW-1:0]    pt_mem [DEPTH];
	logic [FW-1:0]    rdata_q;
	logic [SW+PW-1:0] raddr;

	logic           hit_c;
	logic [SW-1:0]  hit_idx_c;
	logic           avail_c;
	logic [SW-1:0]  avail_idx_c;
	logic [CW-1:0]  cur;
	logic [CW-1:0]  cur_dec;
	logic [QW-1:0]  cur_ext;
	logic [NW-1:0]  lim;
	logic [PSW-1:0] ps_eff;
	logic [QW-1:0]  numer;
	logic [QW-1:0]  quot;
	logic           div_done;
	logic [FW-1:0]  scan_idx;

	// Slot lookup by pid and first unused slot.
	always_comb begin
		hit_c       = 1'b0;
		hit_idx_c   = '0;
		avail_c     = 1'b0;
		avail_idx_c = '0;
		for (int s = PROCESS_SLOTS - 1; s >= 0; s--) begin
			if (slot_valid_q[s] && slot_pid_q[s] == in_pid) begin
				hit_c     = 1'b1;
				hit_idx_c = SW'(s);
			end
			if (!slot_valid_q[s]) begin
				avail_c     = 1'b1;
				avail_idx_c = SW'(s);
			end
		end
	end

	// Frame limit and divider operands.
	assign lim      = (LW'(frame_count) < LW'(FRAMES)) ? NW'(frame_count) : NW'(FRAMES);
	assign ps_eff   = (page_size == '0) ? PSW'(1) : page_size;
	assign numer    = QW'(size_q) + QW'(ps_eff) - QW'(1);
	assign cur      = slot_pages_q[slot_q];
	assign cur_dec  = cur - 1'b1;
	assign cur_ext  = QW'(cur);
	assign scan_idx = f_q[FW-1:0];

	pfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (numer),
		.den    (ps_eff),
		.done   (div_done),
		.quot   (quot)
	);

	// Status toward the controller.
	always_comb begin
		sts.func      = func_q;
		sts.found     = found_q;
		sts.page_ok   = XW'(page_q) < XW'(cur);
		sts.div_done  = div_done;
		sts.same      = quot == cur_ext;
		sts.shrink    = quot < cur_ext;
		sts.grow_fail = (free_q == '0) || (mem_size < size_q) ||
		                (quot > QW'(MAX_PAGES)) || ((quot - cur_ext) > QW'(free_q));
		sts.more_free = cur > keep_q;
		sts.grow_more = (cur < target_q) && (f_q < lim);
		sts.rc_more   = f_q < NW'(FRAMES);
	end

	// Page table read address: translate or the page being dropped.
	assign raddr = cmd.xl_read ? {slot_q, PW'(page_q)} : {slot_q, cur_dec[PW-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.grow_step && !used_q[scan_idx])
			pt_mem[{slot_q, cur[PW-1:0]}] <= scan_idx;
		if (cmd.xl_read || cmd.shr_read)
			rdata_q <= pt_mem[raddr];
	end

	// Control and table state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			for (int s = 0; s < PROCESS_SLOTS; s++)
				slot_pages_q[s] <= '0;
			used_q   <= '0;
			free_q   <= FREE_RST;
			f_q      <= '0;
			keep_q   <= '0;
			target_q <= '0;
			found_q  <= 1'b0;
			slot_q   <= '0;
		end else begin
			if (cmd.load) begin
				found_q <= hit_c;
				slot_q  <= hit_idx_c;
			end
			if (cmd.create_apply && !found_q && avail_c) begin
				slot_valid_q[avail_idx_c] <= 1'b1;
				slot_pages_q[avail_idx_c] <= '0;
			end
			if (cmd.keep_quot)
				keep_q <= CW'(quot);
			if (cmd.keep_zero)
				keep_q <= '0;
			if (cmd.shr_read)
				slot_pages_q[slot_q] <= cur_dec;
			if (cmd.free_step && used_q[rdata_q]) begin
				used_q[rdata_q] <= 1'b0;
				if (NW'(rdata_q) < lim)
					free_q <= free_q + 1'b1;
			end
			if (cmd.slot_clear)
				slot_valid_q[slot_q] <= 1'b0;
			if (cmd.grow_init) begin
				f_q      <= '0;
				target_q <= CW'(quot);
			end
			if (cmd.grow_step) begin
				f_q <= f_q + 1'b1;
				if (!used_q[scan_idx]) begin
					used_q[scan_idx]     <= 1'b1;
					free_q               <= free_q - 1'b1;
					slot_pages_q[slot_q] <= cur + 1'b1;
				end
			end
			if (cmd.rc_init) begin
				f_q    <= '0;
				free_q <= '0;
			end
			if (cmd.rc_step) begin
				f_q <= f_q + 1'b1;
				if (f_q < lim && !used_q[scan_idx])
					free_q <= free_q + 1'b1;
			end
		end
	end

	// Request, pid table and result payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			pid_q  <= in_pid;
			page_q <= in_page;
			size_q <= in_size;
		end
		if (cmd.create_apply) begin
			res_frame_q  <= '0;
			res_status_q <= (found_q || avail_c) ? ST_OK : ST_OUT_OF_MEM;
			if (!found_q && avail_c)
				slot_pid_q[avail_idx_c] <= pid_q;
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
			res_frame_q  <= '0;
		end
		if (cmd.xl_result) begin
			res_status_q <= ST_OK;
			res_frame_q  <= FRW'(rdata_q);
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_frame_q  <= res_frame_q;
		end
	end

	assign out_status = out_status_q;
	assign out_frame  = out_frame_q;

endmodule

[rtl/pfa_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
module pfa_ctrl
	import pfa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic cfg_recount,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_DISPATCH = 10'b0000000010,
		S_DIV      = 10'b0000000100,
		S_DECIDE   = 10'b0000001000,
		S_SHR_CHK  = 10'b0000010000,
		S_SHR_FREE = 10'b0000100000,
		S_GROW     = 10'b0001000000,
		S_XL_WAIT  = 10'b0010000000,
		S_DONE     = 10'b0100000000,
		S_RECOUNT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   pend_q;
	logic   out_valid_q;

	assign s_tready = (state_q == S_IDLE) && !pend_q && !cfg_recount;
	assign m_tvalid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.res_code = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (pend_q) begin
					cmd.rc_init = 1'b1;
					state_d     = S_RECOUNT;
				end else if (s_tvalid && s_tready) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.func == FN_CREATE) begin
					cmd.create_apply = 1'b1;
					state_d          = S_DONE;
				end else if (!sts.found) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_UNKNOWN;
					state_d      = S_DONE;
				end else if (sts.func == FN_TRANSLATE) begin
					if (sts.page_ok) begin
						cmd.xl_read = 1'b1;
						state_d     = S_XL_WAIT;
					end else begin
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_BAD_PAGE;
						state_d      = S_DONE;
					end
				end else if (sts.func == FN_RESIZE) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					cmd.keep_zero = 1'b1;
					state_d       = S_SHR_CHK;
				end
			end
			S_DIV: begin
				if (sts.div_done)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.same) begin
					state_d = S_IDLE;
				end else if (sts.shrink) begin
					cmd.keep_quot = 1'b1;
					state_d       = S_SHR_CHK;
				end else if (sts.grow_fail) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OUT_OF_MEM;
					state_d      = S_DONE;
				end else begin
					cmd.grow_init = 1'b1;
					state_d       = S_GROW;
				end
			end
			S_SHR_CHK: begin
				if (sts.more_free) begin
					cmd.shr_read = 1'b1;
					state_d      = S_SHR_FREE;
				end else begin
					cmd.slot_clear = (sts.func == FN_RELEASE);
					cmd.res_set    = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_SHR_FREE: begin
				cmd.free_step = 1'b1;
				state_d       = S_SHR_CHK;
			end
			S_GROW: begin
				if (sts.grow_more) begin
					cmd.grow_step = 1'b1;
				end else begin
					cmd.res_set = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_XL_WAIT: begin
				cmd.xl_result = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_RECOUNT: begin
				if (sts.rc_more)
					cmd.rc_step = 1'b1;
				else
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, pending recount and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_recount)
				pend_q <= 1'b1;
			else if (cmd.rc_init)
				pend_q <= 1'b0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	// A division that finishes is always followed by the resize decision.
	a_div_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_done) |=> (state_q == S_DECIDE))
		else $error("division done without resize decision");

	// A waiting result is never overwritten.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("result loaded over a waiting result");

	// A stalled result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped before it was taken");

	// No request is taken during a recount.
	a_rc_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RECOUNT) |-> !s_tready)
		else $error("request accepted during recount");
`endif

endmodule

[rtl/paged_frame_allocator.sv]
// Top level of the paged frame allocator: stream ports, APB registers, control and datapath.
// The block takes one request at a time. Create, unknown process and bad page results come
// straight from the dispatch state; a translate adds a page table memory read. Resize runs a
// 22-step restoring division for the page count, then either walks the frame bitmap one frame
// per cycle from frame zero (up to the frame limit) when growing, or frees the released pages
// one at a time when shrinking; release frees every page held. A write to the frame count
// register starts a recount sweep over the bitmap; no request is taken from the write until
// the sweep ends. Results sit in an output register, so the next request is accepted while
// one waits.
module paged_frame_allocator
	import pfa_pkg::*;
#(
	parameter int FRAMES        = 128,
	parameter int PROCESS_SLOTS = 16,
	parameter int MAX_PAGES     = 128
)(
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // pid [7:0], page_index [14:8], new_size_bytes [35:15]
	input  logic [1:0]  s_tuser,   // func [1:0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // frame [6:0]
	output logic [1:0]  m_tuser,   // status [1:0]
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [PSW-1:0] page_size_q;
	logic [MSW-1:0] mem_size_q;
	logic [FCW-1:0] frame_cnt_q;
	logic           wr_en;
	logic [1:0]     reg_idx;
	cmd_t           cmd;
	sts_t           sts;
	status_t        out_status;
	logic [FRW-1:0] out_frame;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PAGE_SIZE_RST;
			mem_size_q  <= MEM_SIZE_RST;
			frame_cnt_q <= FRAME_CNT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PAGE_SIZE: page_size_q <= pwdata[PSW-1:0];
				REG_MEM_SIZE:  mem_size_q  <= pwdata[MSW-1:0];
				REG_FRAME_CNT: frame_cnt_q <= pwdata[FCW-1:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (reg_idx)
			REG_PAGE_SIZE: prdata = 32'(page_size_q);
			REG_MEM_SIZE:  prdata = 32'(mem_size_q);
			REG_FRAME_CNT: prdata = 32'(frame_cnt_q);
			default:       prdata = '0;
		endcase
	end

	pfa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.cfg_recount (wr_en && reg_idx == REG_FRAME_CNT),
		.sts         (sts),
		.cmd         (cmd)
	);

	pfa_dp #(
		.FRAMES        (FRAMES),
		.PROCESS_SLOTS (PROCESS_SLOTS),
		.MAX_PAGES     (MAX_PAGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_func     (func_t'(s_tuser)),
		.in_pid      (s_tdata[7:0]),
		.in_page     (s_tdata[14:8]),
		.in_size     (s_tdata[35:15]),
		.page_size   (page_size_q),
		.mem_size    (mem_size_q),
		.frame_count (frame_cnt_q),
		.out_status  (out_status),
		.out_frame   (out_frame)
	);

	assign m_tdata = 8'(out_frame);
	assign m_tuser = out_status;

endmodule

[tb/pfa_checker.sv]
// Checker of the paged frame allocator: tracks its state, predicts each result and compares.
`timescale 1ns / 100ps

module pfa_checker
	import pfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // pid [7:0], page_index [14:8], new_size_bytes [35:15]
	input  logic [1:0]  s_tuser,   // func [1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // frame [6:0]
	input  logic [1:0]  m_tuser,   // status [1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          failures,
	output int          pending,
	output int          results_seen
);

	localparam int NSLOT = 16;
	localparam int NPAGE = 128;
	localparam int NFRAME = 128;

	typedef struct packed {
		status_t    status;
		logic [6:0] frame;
	} alloc_result_t;

	alloc_result_t awaited_q[$];

	// Shadow copy of the allocator state and its registers.
	logic [PSW-1:0] page_size;
	logic [MSW-1:0] mem_size;
	logic [FCW-1:0] frame_cnt;
	logic [7:0]     slot_pid [NSLOT];
	bit             slot_valid [NSLOT];
	int             slot_pages [NSLOT];
	logic [6:0]     page_frames [NSLOT][NPAGE];
	bit             frame_used [NFRAME];
	int             free_frames;

	assign pending = awaited_q.size();

	function automatic int frame_limit();
		return (frame_cnt > NFRAME) ? NFRAME : int'(frame_cnt);
	endfunction

	function automatic void recount_free();
		free_frames = 0;
		for (int i = 0; i < frame_limit(); i++)
			if (!frame_used[i])
				free_frames++;
	endfunction

	// Drop the highest pages of a slot until it holds keep pages.
	function automatic void shrink_slot(int s, int keep);
		int f;
		while (slot_pages[s] > keep) begin
			slot_pages[s]--;
			f = page_frames[s][slot_pages[s]];
			if (frame_used[f]) begin
				frame_used[f] = 0;
				if (f < frame_limit())
					free_frames++;
			end
		end
	endfunction

	function automatic void clear_state();
		page_size = PAGE_SIZE_RST;
		mem_size = MEM_SIZE_RST;
		frame_cnt = FRAME_CNT_RST;
		for (int s = 0; s < NSLOT; s++) begin
			slot_valid[s] = 0;
			slot_pages[s] = 0;
		end
		for (int i = 0; i < NFRAME; i++)
			frame_used[i] = 0;
		recount_free();
	endfunction

	// Work out the effect of one request and queue its result, if it has one.
	function automatic void apply_request(func_t fn, logic [7:0] pid, logic [6:0] pg,
		logic [20:0] sz);
		int s, ps, pages, cur, f;
		bit answers;
		alloc_result_t r;
		s = -1;
		for (int k = 0; k < NSLOT; k++)
			if (s < 0 && slot_valid[k] && slot_pid[k] == pid)
				s = k;
		r.status = ST_OK;
		r.frame = '0;
		answers = 1;
		if (fn == FN_CREATE) begin
			if (s < 0) begin
				r.status = ST_OUT_OF_MEM;
				for (int k = 0; k < NSLOT; k++)
					if (r.status == ST_OUT_OF_MEM && !slot_valid[k]) begin
						slot_valid[k] = 1;
						slot_pid[k] = pid;
						slot_pages[k] = 0;
						r.status = ST_OK;
					end
			end
		end else if (s < 0) begin
			r.status = ST_UNKNOWN;
		end else if (fn == FN_TRANSLATE) begin
			if (pg < slot_pages[s])
				r.frame = page_frames[s][pg];
			else
				r.status = ST_BAD_PAGE;
		end else if (fn == FN_RESIZE) begin
			ps = (page_size == 0) ? 1 : int'(page_size);
			pages = (int'(sz) + ps - 1) / ps;
			cur = slot_pages[s];
			if (pages == cur) begin
				answers = 0;
			end else if (pages < cur) begin
				shrink_slot(s, pages);
			end else if (free_frames == 0 || mem_size < sz || pages > NPAGE ||
				pages - cur > free_frames) begin
				r.status = ST_OUT_OF_MEM;
			end else begin
				// Grow from the lowest free frames upward.
				f = 0;
				while (slot_pages[s] < pages) begin
					while (f < frame_limit() && frame_used[f])
						f++;
					if (f >= frame_limit())
						break;
					frame_used[f] = 1;
					free_frames--;
					page_frames[s][slot_pages[s]] = f[6:0];
					slot_pages[s]++;
				end
			end
		end else begin
			shrink_slot(s, 0);
			slot_valid[s] = 0;
		end
		if (answers)
			awaited_q.push_back(r);
	endfunction

	// Register writes, requests and results, in that order at each edge.
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			clear_state();
			awaited_q.delete();
			failures <= 0;
			results_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PAGE_SIZE: page_size = pwdata[PSW-1:0];
					REG_MEM_SIZE:  mem_size = pwdata[MSW-1:0];
					REG_FRAME_CNT: begin
						frame_cnt = pwdata[FCW-1:0];
						recount_free();
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				apply_request(func_t'(s_tuser), s_tdata[7:0], s_tdata[14:8], s_tdata[35:15]);
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (awaited_q.size() == 0) begin
					failures <= failures + 1;
					if (failures < 10)
						$display("%0t: result with none awaited: status %0d frame %0d",
							$realtime, m_tuser, m_tdata);
				end else begin
					want = awaited_q.pop_front();
					if (m_tuser !== want.status || m_tdata !== {1'b0, want.frame}) begin
						failures <= failures + 1;
						if (failures < 10)
							$display("%0t: mismatch: awaited status %0d frame %0d, got %0d %0d",
								$realtime, want.status, want.frame, m_tuser, m_tdata);
					end
				end
			end
		end
	end

endmodule

[tb/paged_frame_allocator_tb.sv]
// Testbench top of the paged frame allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module paged_frame_allocator_tb
	import pfa_pkg::*;
();

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 400;
	localparam int RANDOM_PER_PHASE = 205;
	localparam int PHASES = 6;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // pid [7:0], page_index [14:8], new_size_bytes [35:15]
	logic [1:0]  s_tuser;   // func [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // frame [6:0]
	logic [1:0]  m_tuser;   // status [1:0]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int failures;
	int pending;
	int results_seen;
	int cycles;
	int sent_by_func [4];
	int cur_page_size;
	bit no_gaps;

	paged_frame_allocator uut (.*);

	pfa_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready), .failures(failures), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: a random stall before each result.
	initial begin
		int stall;
		m_tready <= 0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// One request, after a random gap.
	task automatic send_request(func_t fn, logic [7:0] pid, logic [6:0] pg, logic [20:0] sz);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= fn;
		s_tdata <= {4'b0, sz, pg, pid};
		sent_by_func[fn]++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	// Let every awaited result arrive, then give a resize with no result time to finish.
	task automatic settle();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_request();
		func_t fn;
		logic [7:0] pid;
		logic [6:0] pg;
		int sz, pick;
		pick = $urandom_range(0, 99);
		fn = pick < 25 ? FN_CREATE : pick < 55 ? FN_TRANSLATE : pick < 85 ? FN_RESIZE
			: FN_RELEASE;
		// A small pool of pids keeps most requests on registered processes.
		pid = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 19)) : 8'($urandom);
		pg = $urandom_range(0, 1) ? 7'($urandom_range(0, 7)) : 7'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			sz = $urandom_range(0, cur_page_size * 12);
		else if (pick < 90)
			sz = $urandom_range(0, cur_page_size * 130);
		else
			sz = $urandom_range(0, 2097151);
		if (sz > 2097151)
			sz = 2097151;
		send_request(fn, pid, pg, sz[20:0]);
	endtask

	initial begin
		int page_sizes [PHASES] = '{1, 4096, 0, 100, 8191, 64};
		int mem_sizes  [PHASES] = '{128, 1048576, 2097151, 5000, 0, 8192};
		int frame_cnts [PHASES] = '{128, 40, 255, 1, 0, 128};
		arst_n <= 0;
		s_tvalid <= 0;
		s_tdata <= '0;
		s_tuser <= FN_CREATE;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= '0;
		pwdata <= '0;
		cycles <= 0;
		no_gaps = 0;
		cur_page_size = 32;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed requests with the reset register values.
		send_request(FN_CREATE, 8'd0, 7'd0, 21'd0);
		send_request(FN_CREATE, 8'd255, 7'd127, 21'h1FFFFF);
		send_request(FN_CREATE, 8'd0, 7'd0, 21'd0);            // already registered
		send_request(FN_TRANSLATE, 8'd9, 7'd0, 21'd0);         // unknown pid
		send_request(FN_RESIZE, 8'd9, 7'd0, 21'd64);
		send_request(FN_RELEASE, 8'd9, 7'd0, 21'd0);
		send_request(FN_RESIZE, 8'd0, 7'd0, 21'd0);            // same page count
		send_request(FN_RESIZE, 8'd0, 7'd0, 21'd100);
		send_request(FN_TRANSLATE, 8'd0, 7'd0, 21'd0);
		send_request(FN_TRANSLATE, 8'd0, 7'd3, 21'd0);
		send_request(FN_TRANSLATE, 8'd0, 7'd4, 21'd0);         // past the end
		send_request(FN_TRANSLATE, 8'd0, 7'd127, 21'd0);
		send_request(FN_RESIZE, 8'd0, 7'd0, 21'd33);           // shrink
		send_request(FN_RESIZE, 8'd255, 7'd0, 21'h1FFFFF);     // beyond memory
		send_request(FN_RESIZE, 8'd255, 7'd0, 21'd4097);
		send_request(FN_RESIZE, 8'd255, 7'd0, 21'd4032);       // 126 pages
		send_request(FN_RESIZE, 8'd0, 7'd0, 21'd4096);         // no frame left
		send_request(FN_TRANSLATE, 8'd255, 7'd125, 21'd0);
		send_request(FN_RELEASE, 8'd255, 7'd0, 21'd0);
		send_request(FN_RELEASE, 8'd0, 7'd0, 21'd0);

		// Each phase: new register values, then random requests.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_reg(REG_PAGE_SIZE, page_sizes[p]);
			write_reg(REG_MEM_SIZE, mem_sizes[p]);
			write_reg(REG_FRAME_CNT, frame_cnts[p]);
			cur_page_size = (page_sizes[p] == 0) ? 1 : page_sizes[p];
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (i % 60 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				random_request();
			end
			no_gaps = 0;
		end
		settle();

		$display("covered %0d creates, %0d translates, %0d resizes, %0d releases",
			sent_by_func[FN_CREATE], sent_by_func[FN_TRANSLATE], sent_by_func[FN_RESIZE],
			sent_by_func[FN_RELEASE]);
		$display("%0d results checked over %0d register settings", results_seen, PHASES + 1);
		if (failures == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
